// ----- hw/rtl/famn_pkg.sv -----
// Shared types and constants for the frame accumulator with min/max normalization.
// Used by the top level, the scaling lane and the port checker; depends on nothing.
package famn_pkg;

    // Default size of the pixel store.
    localparam int unsigned PIXELS_DEFAULT = 65536;

    localparam int unsigned CHANNELS = 4;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned BYTE_W   = 8;

    // Item opcodes.
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_ACCUM   = 3'd1,
        OP_RESTART = 3'd2,
        OP_FOLD    = 3'd3,
        OP_EMIT    = 3'd4
    } opcode_t;

    // Configuration register indexes (register i at byte address 8*i).
    localparam logic [2:0] REG_RANGE_MODE  = 3'd0;
    localparam logic [2:0] REG_RANGE_BLUE  = 3'd1;
    localparam logic [2:0] REG_RANGE_GREEN = 3'd2;
    localparam logic [2:0] REG_RANGE_RED   = 3'd3;
    localparam logic [2:0] REG_RANGE_ALPHA = 3'd4;

    localparam logic [SUM_W-1:0] SUM_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] BYTE_FULL   = 8'hFF;

    // Payload widths on the streams.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 288;

    // Control state of the top level.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ----- hw/rtl/famn_scale.sv -----
// One normalization lane: clamps a sum to [lo, hi] and scales it to 0..255.
// The quotient is found by restoring division, one bit per cycle. Uses famn_pkg.
module famn_scale
    import famn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  n,
    input  logic [SUM_W-1:0]  lo,
    input  logic [SUM_W-1:0]  hi,
    output logic              done,
    output logic [BYTE_W-1:0] q
);

    localparam int unsigned REM_W = SUM_W + BYTE_W;
    localparam logic [3:0]  LAST_STEP = 4'(BYTE_W);

    logic              busy_reg;
    logic [3:0]        cnt_reg;
    logic              done_reg;
    logic              empty_reg;
    logic [SUM_W-1:0]  diff_reg;
    logic [REM_W-1:0]  den_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [BYTE_W-1:0] q_reg;
    logic [SUM_W-1:0]  clamped;

    // Clamp the sum into the range.
    always_comb
    begin
        if (n < lo)
            clamped = lo;
        else if (n > hi)
            clamped = hi;
        else
            clamped = n;
    end

    // Control: first form the scaled numerator, then one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: numerator is diff * 255, divisor starts shifted to the top quotient bit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            empty_reg <= (lo >= hi);
            diff_reg  <= clamped - lo;
            den_reg   <= {1'b0, hi - lo, 7'b0};
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                rem_reg <= {diff_reg, 8'b0} - {8'b0, diff_reg};
                q_reg   <= '0;
            end
            else
            begin
                if (rem_reg >= den_reg)
                begin
                    rem_reg <= rem_reg - den_reg;
                    q_reg   <= {q_reg[BYTE_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[BYTE_W-2:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign q    = empty_reg ? BYTE_FULL : q_reg;

endmodule

// ----- hw/rtl/frame_accumulate_minmax_normalize.sv -----
// Top level of the frame accumulator with min/max normalization.
// Holds the pixel store and the running statistics; uses famn_pkg and famn_scale.
//
// Usage: items enter on the s_* stream (tuser carries the opcode, tdata the pixel
// index and four bytes); one result per item leaves on the m_* stream with the four
// normalized bytes and the running minima and maxima after that item. Ranges and the
// range mode are to be written on the APB port only while the block is idle; the
// block itself does not enforce this. Items are handled one at a time. The store
// has one read port with a registered read, so an item reads its pixel at acceptance,
// and clear and accumulate write the row back in the execute state that follows.
// Every item passes the execute and done states on its way to the output register;
// emit also runs the scaling lanes, a 9-step restoring divider per channel, between
// the two, for a pixel inside the store. The block is ready for the next item once
// the result is in the output register, while that result still waits to be taken.
// If the receiver stalls, a finished result holds the block until the output register
// is free again; the output stays stable until taken.
// Reset zeroes the configuration and the maxima, sets the minima to all ones, then
// sweeps the store to zero, one pixel per cycle; no item is accepted during that sweep.
module frame_accumulate_minmax_normalize
    import famn_pkg::*;
#(
    parameter int unsigned PIXELS = PIXELS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: pixel_index[15:0], in_blue, in_green, in_red, in_alpha.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser from bit 0: opcode[2:0].
    input  logic [2:0]           s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: out_blue, out_green, out_red, out_alpha, min_blue, min_green,
    // min_red, min_alpha, max_blue, max_green, max_red, max_alpha.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
    localparam int unsigned ROW_W = CHANNELS * SUM_W;

    // Configuration registers.
    logic             range_mode_reg;
    logic [63:0]      given_range_reg [CHANNELS];
    logic [2:0]       cfg_sel;

    assign cfg_sel = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_mode_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                given_range_reg[c] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_sel)
                REG_RANGE_MODE:  range_mode_reg     <= pwdata[0];
                REG_RANGE_BLUE:  given_range_reg[0] <= pwdata;
                REG_RANGE_GREEN: given_range_reg[1] <= pwdata;
                REG_RANGE_RED:   given_range_reg[2] <= pwdata;
                REG_RANGE_ALPHA: given_range_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_sel)
            REG_RANGE_MODE:  prdata = {63'b0, range_mode_reg};
            REG_RANGE_BLUE:  prdata = given_range_reg[0];
            REG_RANGE_GREEN: prdata = given_range_reg[1];
            REG_RANGE_RED:   prdata = given_range_reg[2];
            REG_RANGE_ALPHA: prdata = given_range_reg[3];
            default:         prdata = '0;
        endcase
    end

    // Control and item registers.
    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    opcode_t           op_reg;
    logic              inside_reg;
    logic [AW-1:0]     addr_reg;
    logic [BYTE_W-1:0] add_reg [CHANNELS];
    logic [BYTE_W-1:0] res_reg [CHANNELS];
    logic [SUM_W-1:0]  min_reg [CHANNELS];
    logic [SUM_W-1:0]  max_reg [CHANNELS];
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              s_fire;
    logic              out_free;
    logic [AW-1:0]     in_addr;
    logic              in_inside;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_addr   = AW'(s_tdata[15:0]);
    assign in_inside = ({9'b0, s_tdata[15:0]} < 25'(PIXELS));

    // Pixel store: one row holds the four sums, blue in the low bits.
    logic [ROW_W-1:0] mem [PIXELS];
    logic [ROW_W-1:0] rd_reg;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            rd_reg <= mem[in_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[addr_reg] <= wr_row;
    end

    // Write back for clear and accumulate.
    assign wr_en = (state_reg == ST_EXEC) && inside_reg &&
                   ((op_reg == OP_CLEAR) || (op_reg == OP_ACCUM));

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (op_reg == OP_CLEAR)
                wr_row[c*SUM_W +: SUM_W] = '0;
            else
                wr_row[c*SUM_W +: SUM_W] = rd_reg[c*SUM_W +: SUM_W] +
                                           {24'b0, add_reg[c]};
        end
    end

    // Scaling lanes, one per channel.
    logic              lane_start;
    logic [CHANNELS-1:0] lane_done;
    logic [BYTE_W-1:0] lane_q [CHANNELS];
    logic [SUM_W-1:0]  lane_lo [CHANNELS];
    logic [SUM_W-1:0]  lane_hi [CHANNELS];

    assign lane_start = (state_reg == ST_EXEC) && (op_reg == OP_EMIT) && inside_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        assign lane_lo[g] = range_mode_reg ? given_range_reg[g][31:0]  : min_reg[g];
        assign lane_hi[g] = range_mode_reg ? given_range_reg[g][63:32] : max_reg[g];

        famn_scale u_scale (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .n     (rd_reg[g*SUM_W +: SUM_W]),
            .lo    (lane_lo[g]),
            .hi    (lane_hi[g]),
            .done  (lane_done[g]),
            .q     (lane_q[g])
        );
    end

    // Sequencer: sweep after reset, then one item at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                min_reg[c] <= SUM_ALL_ONES;
                max_reg[c] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (s_fire)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (op_reg == OP_RESTART)
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            min_reg[c] <= SUM_ALL_ONES;
                            max_reg[c] <= '0;
                        end
                    end
                    else if ((op_reg == OP_FOLD) && inside_reg)
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            if (rd_reg[c*SUM_W +: SUM_W] < min_reg[c])
                                min_reg[c] <= rd_reg[c*SUM_W +: SUM_W];
                            if (rd_reg[c*SUM_W +: SUM_W] > max_reg[c])
                                max_reg[c] <= rd_reg[c*SUM_W +: SUM_W];
                        end
                    end
                    state_reg <= lane_start ? ST_DIV : ST_DONE;
                end
                ST_DIV:
                begin
                    if (&lane_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Item payload and result bytes.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg     <= opcode_t'(s_tuser);
            inside_reg <= in_inside;
            addr_reg   <= in_addr;
            for (int c = 0; c < CHANNELS; c++)
                add_reg[c] <= s_tdata[16 + c*BYTE_W +: BYTE_W];
        end
        if (state_reg == ST_EXEC)
        begin
            for (int c = 0; c < CHANNELS; c++)
                res_reg[c] <= '0;
        end
        else if ((state_reg == ST_DIV) && (&lane_done))
        begin
            for (int c = 0; c < CHANNELS; c++)
                res_reg[c] <= lane_q[c];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                out_data_reg[c*BYTE_W +: BYTE_W]      <= res_reg[c];
                out_data_reg[32 + c*SUM_W +: SUM_W]   <= min_reg[c];
                out_data_reg[160 + c*SUM_W +: SUM_W]  <= max_reg[c];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/famn_checker.sv -----
// Port checker for the frame accumulator; watches the top level's streams only.
// Uses famn_pkg and is attached to the top level by the bind at the end of the file.
module famn_checker
    import famn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Items are worked on one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // A result is only withdrawn after it was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without being taken");

    // Taking an item while no result waits does not raise m_tvalid straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind frame_accumulate_minmax_normalize famn_checker u_famn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
